// ----- hw/rtl/lcgmm_pkg.sv -----
package lcgmm_pkg;

    localparam int VALUE_W = 31;
    localparam int SCALE_W = 24;
    localparam int KIND_W = 2;
    localparam int STATUS_W = 2;
    localparam int STORE_DEPTH = 16384;
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int COUNT_W = $clog2(STORE_DEPTH + 1);
    localparam int PROD_W = 2 * VALUE_W;
    localparam int ACC_W = PROD_W + 1;
    localparam int SHIFT_W = ACC_W + 1;
    localparam int DIVISOR_W = VALUE_W + 1;
    localparam int QUOT_W = VALUE_W + SCALE_W;
    localparam int STEP_W = $clog2(ACC_W + 1);
    localparam int CFG_INDEX_W = 3;
    localparam int S_DATA_W = ((ADDR_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((VALUE_W + SCALE_W + 7) / 8) * 8;

    localparam logic [STEP_W-1:0] GEN_STEPS = STEP_W'(ACC_W);
    localparam logic [STEP_W-1:0] SCALE_STEPS = STEP_W'(QUOT_W);

    localparam logic [VALUE_W-1:0] SEED_RESET = VALUE_W'(1);
    localparam logic [VALUE_W-1:0] MODULUS_RESET = VALUE_W'(2147483647);
    localparam logic [VALUE_W-1:0] MULTIPLIER_RESET = VALUE_W'(16807);
    localparam logic [VALUE_W-1:0] INCREMENT_RESET = VALUE_W'(0);
    localparam logic [SCALE_W-1:0] UPPER_RESET = SCALE_W'(65536);
    localparam logic [VALUE_W-1:0] VALUE_ONES = {VALUE_W{1'b1}};
    localparam logic [SCALE_W-1:0] SCALE_ONES = {SCALE_W{1'b1}};

    typedef enum logic [KIND_W-1:0] {
        KIND_GENERATE = 2'd0,
        KIND_READ     = 2'd1,
        KIND_RESTART  = 2'd2,
        KIND_UNUSED   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 2'd0,
        ST_FULL          = 2'd1,
        ST_NOT_GENERATED = 2'd2,
        ST_ZERO_RANGE    = 2'd3
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SEED       = 3'd0,
        REG_MODULUS    = 3'd1,
        REG_MULTIPLIER = 3'd2,
        REG_INCREMENT  = 3'd3,
        REG_UPPER      = 3'd4
    } reg_index_t;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_LOAD = 8'b0000_0100,
        S_DIV  = 8'b0000_1000,
        S_RD   = 8'b0001_0000,
        S_OFF  = 8'b0010_0000,
        S_FIN  = 8'b0100_0000,
        S_HOLD = 8'b1000_0000
    } state_t;

endpackage

// ----- hw/rtl/lcg_with_minmax_normalizer.sv -----
// path: generate through S_MUL, S_LOAD, S_DIV, S_FIN and S_HOLD; read through S_RD,
// S_OFF and then the same; zero-range read S_RD, S_OFF, S_HOLD; restart, unused kind
// and refused items straight to S_HOLD, which puts the result word on m_tdata
// throughput: one word at a time; the bit-serial remainder/divide unit takes one step
// per bit of the 63-bit sum for the modulo and of the 55-bit scaling quotient
// reset: async active low; registers to defaults, generator at 1, store empty, contents kept
module lcg_with_minmax_normalizer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lcgmm_pkg::S_DATA_W-1:0]      s_tdata,   // index
    input  logic [lcgmm_pkg::KIND_W-1:0]        s_tuser,   // kind
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lcgmm_pkg::M_DATA_W-1:0]      m_tdata,   // raw_value, scaled_value
    output logic [lcgmm_pkg::STATUS_W-1:0]      m_tuser,   // status
    input  logic                                cfg_we,
    input  logic [lcgmm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lcgmm_pkg::VALUE_W-1:0]       cfg_data
);

    // configuration
    logic [lcgmm_pkg::VALUE_W-1:0] seed_reg;
    logic [lcgmm_pkg::VALUE_W-1:0] modulus_reg;
    logic [lcgmm_pkg::VALUE_W-1:0] multiplier_reg;
    logic [lcgmm_pkg::VALUE_W-1:0] increment_reg;
    logic [lcgmm_pkg::SCALE_W-1:0] upper_reg;

    // generator state
    logic [lcgmm_pkg::VALUE_W-1:0] current_reg;
    logic [lcgmm_pkg::COUNT_W-1:0] count_reg;
    logic [lcgmm_pkg::VALUE_W-1:0] lowest_reg;
    logic [lcgmm_pkg::VALUE_W-1:0] highest_reg;

    // sequencer and shared datapath
    lcgmm_pkg::state_t              state_reg;
    logic                           is_gen_reg;
    logic [lcgmm_pkg::ADDR_W-1:0]   idx_reg;
    logic [lcgmm_pkg::VALUE_W-1:0]  op_a_reg;
    logic [lcgmm_pkg::VALUE_W-1:0]  op_b_reg;
    logic [lcgmm_pkg::PROD_W-1:0]   prod_reg;
    logic [lcgmm_pkg::SHIFT_W-1:0]  shift_reg;
    logic [lcgmm_pkg::DIVISOR_W-1:0] rem_reg;
    logic [lcgmm_pkg::DIVISOR_W-1:0] divisor_reg;
    logic [lcgmm_pkg::STEP_W-1:0]   step_reg;
    logic [lcgmm_pkg::VALUE_W-1:0]  mem_q_reg;

    // staged result and output word
    logic [lcgmm_pkg::VALUE_W-1:0]  res_raw_reg;
    logic [lcgmm_pkg::SCALE_W-1:0]  res_scaled_reg;
    lcgmm_pkg::status_t             res_status_reg;
    logic                           out_valid_reg;
    logic [lcgmm_pkg::VALUE_W-1:0]  out_raw_reg;
    logic [lcgmm_pkg::SCALE_W-1:0]  out_scaled_reg;
    lcgmm_pkg::status_t             out_status_reg;

    logic [lcgmm_pkg::VALUE_W-1:0]  raw_store [lcgmm_pkg::STORE_DEPTH];

    logic                           in_fire;
    lcgmm_pkg::kind_t               in_kind;
    logic [lcgmm_pkg::ADDR_W-1:0]   in_index;
    logic [lcgmm_pkg::ACC_W-1:0]    acc;
    logic [lcgmm_pkg::DIVISOR_W:0]  trial;
    logic                           trial_ge;
    logic [lcgmm_pkg::DIVISOR_W:0]  trial_diff;
    logic [lcgmm_pkg::VALUE_W-1:0]  new_value;
    logic [lcgmm_pkg::VALUE_W-1:0]  offset;
    logic                           store_we;

    assign in_fire  = s_tvalid && s_tready;
    assign in_kind  = lcgmm_pkg::kind_t'(s_tuser);
    assign in_index = s_tdata[lcgmm_pkg::ADDR_W-1:0];
    assign s_tready = (state_reg == lcgmm_pkg::S_IDLE);

    assign acc = {1'b0, prod_reg} + lcgmm_pkg::ACC_W'(increment_reg);

    // one restoring step: shift in the next dividend bit, subtract when it fits
    assign trial      = {rem_reg, shift_reg[lcgmm_pkg::SHIFT_W-1]};
    assign trial_ge   = (trial >= {1'b0, divisor_reg});
    assign trial_diff = trial - {1'b0, divisor_reg};

    assign new_value = rem_reg[lcgmm_pkg::VALUE_W-1:0];
    assign offset    = (mem_q_reg >= lowest_reg) ? (mem_q_reg - lowest_reg)
                                                 : '0;
    assign store_we  = (state_reg == lcgmm_pkg::S_FIN) && is_gen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg       <= lcgmm_pkg::SEED_RESET;
            modulus_reg    <= lcgmm_pkg::MODULUS_RESET;
            multiplier_reg <= lcgmm_pkg::MULTIPLIER_RESET;
            increment_reg  <= lcgmm_pkg::INCREMENT_RESET;
            upper_reg      <= lcgmm_pkg::UPPER_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lcgmm_pkg::REG_SEED:       seed_reg       <= cfg_data;
                lcgmm_pkg::REG_MODULUS:    modulus_reg    <= cfg_data;
                lcgmm_pkg::REG_MULTIPLIER: multiplier_reg <= cfg_data;
                lcgmm_pkg::REG_INCREMENT:  increment_reg  <= cfg_data;
                lcgmm_pkg::REG_UPPER:      upper_reg      <= cfg_data[lcgmm_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            raw_store[count_reg[lcgmm_pkg::ADDR_W-1:0]] <= new_value;
        end
        mem_q_reg <= raw_store[idx_reg];
    end

    // shared datapath, loaded by the sequencer
    always_ff @(posedge clk)
    begin
        case (state_reg)
            lcgmm_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    idx_reg  <= in_index;
                    op_a_reg <= multiplier_reg;
                    op_b_reg <= current_reg;
                    divisor_reg <= (modulus_reg == '0)
                                 ? {1'b1, {lcgmm_pkg::VALUE_W{1'b0}}}
                                 : {1'b0, modulus_reg};
                end
            end
            lcgmm_pkg::S_MUL:
            begin
                prod_reg <= lcgmm_pkg::PROD_W'(op_a_reg) * lcgmm_pkg::PROD_W'(op_b_reg);
            end
            lcgmm_pkg::S_LOAD:
            begin
                rem_reg <= '0;
                if (is_gen_reg)
                begin
                    shift_reg <= {acc, 1'b0};
                    step_reg  <= lcgmm_pkg::GEN_STEPS;
                end
                else
                begin
                    shift_reg <= {prod_reg[lcgmm_pkg::QUOT_W-1:0],
                                  {(lcgmm_pkg::SHIFT_W - lcgmm_pkg::QUOT_W){1'b0}}};
                    step_reg  <= lcgmm_pkg::SCALE_STEPS;
                end
            end
            lcgmm_pkg::S_DIV:
            begin
                rem_reg   <= trial_ge ? trial_diff[lcgmm_pkg::DIVISOR_W-1:0]
                                      : trial[lcgmm_pkg::DIVISOR_W-1:0];
                shift_reg <= {shift_reg[lcgmm_pkg::SHIFT_W-2:0], trial_ge};
                step_reg  <= step_reg - 1'b1;
            end
            lcgmm_pkg::S_OFF:
            begin
                op_a_reg    <= offset;
                op_b_reg    <= lcgmm_pkg::VALUE_W'(upper_reg);
                divisor_reg <= {1'b0, highest_reg - lowest_reg};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lcgmm_pkg::S_IDLE;
            is_gen_reg     <= 1'b0;
            current_reg    <= lcgmm_pkg::SEED_RESET;
            count_reg      <= '0;
            lowest_reg     <= lcgmm_pkg::VALUE_ONES;
            highest_reg    <= '0;
            res_raw_reg    <= '0;
            res_scaled_reg <= '0;
            res_status_reg <= lcgmm_pkg::ST_OK;
            out_valid_reg  <= 1'b0;
            out_raw_reg    <= '0;
            out_scaled_reg <= '0;
            out_status_reg <= lcgmm_pkg::ST_OK;
        end
        else
        begin
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                lcgmm_pkg::S_IDLE:
                begin
                    if (in_fire)
                    begin
                        res_raw_reg    <= '0;
                        res_scaled_reg <= '0;
                        res_status_reg <= lcgmm_pkg::ST_OK;
                        is_gen_reg     <= (in_kind == lcgmm_pkg::KIND_GENERATE);
                        state_reg      <= lcgmm_pkg::S_HOLD;
                        case (in_kind)
                            lcgmm_pkg::KIND_GENERATE:
                            begin
                                if (count_reg >= lcgmm_pkg::COUNT_W'(lcgmm_pkg::STORE_DEPTH))
                                begin
                                    res_status_reg <= lcgmm_pkg::ST_FULL;
                                end
                                else
                                begin
                                    state_reg <= lcgmm_pkg::S_MUL;
                                end
                            end
                            lcgmm_pkg::KIND_READ:
                            begin
                                if (lcgmm_pkg::COUNT_W'(in_index) >= count_reg)
                                begin
                                    res_status_reg <= lcgmm_pkg::ST_NOT_GENERATED;
                                end
                                else
                                begin
                                    state_reg <= lcgmm_pkg::S_RD;
                                end
                            end
                            lcgmm_pkg::KIND_RESTART:
                            begin
                                current_reg <= seed_reg;
                                count_reg   <= '0;
                                lowest_reg  <= lcgmm_pkg::VALUE_ONES;
                                highest_reg <= '0;
                                res_raw_reg <= seed_reg;
                            end
                            default: ;
                        endcase
                    end
                end
                lcgmm_pkg::S_RD:
                begin
                    // store read address settles, data lands in mem_q_reg
                    state_reg <= lcgmm_pkg::S_OFF;
                end
                lcgmm_pkg::S_OFF:
                begin
                    res_raw_reg <= mem_q_reg;
                    if (highest_reg <= lowest_reg)
                    begin
                        res_status_reg <= lcgmm_pkg::ST_ZERO_RANGE;
                        state_reg      <= lcgmm_pkg::S_HOLD;
                    end
                    else
                    begin
                        state_reg <= lcgmm_pkg::S_MUL;
                    end
                end
                lcgmm_pkg::S_MUL:
                begin
                    state_reg <= lcgmm_pkg::S_LOAD;
                end
                lcgmm_pkg::S_LOAD:
                begin
                    state_reg <= lcgmm_pkg::S_DIV;
                end
                lcgmm_pkg::S_DIV:
                begin
                    if (step_reg == lcgmm_pkg::STEP_W'(1))
                    begin
                        state_reg <= lcgmm_pkg::S_FIN;
                    end
                end
                lcgmm_pkg::S_FIN:
                begin
                    if (is_gen_reg)
                    begin
                        current_reg <= new_value;
                        count_reg   <= count_reg + 1'b1;
                        res_raw_reg <= new_value;
                        if (new_value < lowest_reg)
                        begin
                            lowest_reg <= new_value;
                        end
                        if (new_value > highest_reg)
                        begin
                            highest_reg <= new_value;
                        end
                    end
                    else
                    begin
                        // quotient sits in the low bits of the shift register
                        res_scaled_reg <= (|shift_reg[lcgmm_pkg::QUOT_W-1:lcgmm_pkg::SCALE_W])
                                        ? lcgmm_pkg::SCALE_ONES
                                        : shift_reg[lcgmm_pkg::SCALE_W-1:0];
                    end
                    state_reg <= lcgmm_pkg::S_HOLD;
                end
                lcgmm_pkg::S_HOLD:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_raw_reg    <= res_raw_reg;
                        out_scaled_reg <= res_scaled_reg;
                        out_status_reg <= res_status_reg;
                        state_reg      <= lcgmm_pkg::S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= lcgmm_pkg::S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(lcgmm_pkg::M_DATA_W - lcgmm_pkg::VALUE_W - lcgmm_pkg::SCALE_W){1'b0}},
                       out_scaled_reg, out_raw_reg};
    assign m_tuser  = out_status_reg;

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_tready)
        else $error("input accepted again while an item is in flight");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= lcgmm_pkg::COUNT_W'(lcgmm_pkg::STORE_DEPTH))
        else $error("generated count beyond store depth");

    a_minmax_order: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (lowest_reg <= highest_reg))
        else $error("running min above running max");

    a_value_below_modulus: assert property (@(posedge clk) disable iff (!rst_n)
        store_we |-> ({1'b0, new_value} < divisor_reg))
        else $error("generated value not reduced by modulus");
`endif

endmodule

// ----- dv/lcg_with_minmax_normalizer_test.sv -----
module lcg_with_minmax_normalizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        lcgmm_pkg::kind_t               kind;
        logic [lcgmm_pkg::ADDR_W-1:0]   index;
    } lcg_item_t;

    typedef struct packed {
        logic [lcgmm_pkg::VALUE_W-1:0]  raw;
        logic [lcgmm_pkg::SCALE_W-1:0]  scaled;
        lcgmm_pkg::status_t             status;
    } lcg_result_t;

    // indexes 5..7 have no register behind them
    localparam logic [lcgmm_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED_LO = 3'd5;
    localparam int MAX_REPORTS = 10;
    localparam int SETTLE_CYCLES = 80;
    localparam logic [lcgmm_pkg::ADDR_W-1:0] INDEX_TOP = {lcgmm_pkg::ADDR_W{1'b1}};

    logic                                   clk = 1'b0;
    logic                                   rst_n = 1'b0;
    logic                                   s_tvalid = 1'b0;
    logic                                   s_tready;
    logic [lcgmm_pkg::S_DATA_W-1:0]         s_tdata = '0;   // index, zero filled
    logic [lcgmm_pkg::KIND_W-1:0]           s_tuser = '0;   // kind
    logic                                   m_tvalid;
    logic                                   m_tready = 1'b0;
    logic [lcgmm_pkg::M_DATA_W-1:0]         m_tdata;        // raw_value, scaled_value
    logic [lcgmm_pkg::STATUS_W-1:0]         m_tuser;        // status
    logic                                   cfg_we = 1'b0;
    logic [lcgmm_pkg::CFG_INDEX_W-1:0]      cfg_index = '0;
    logic [lcgmm_pkg::VALUE_W-1:0]          cfg_data = '0;

    // shadow of the block: configuration and generator state
    logic [lcgmm_pkg::VALUE_W-1:0]          seed_reg;
    logic [lcgmm_pkg::VALUE_W-1:0]          modulus_reg;
    logic [lcgmm_pkg::VALUE_W-1:0]          multiplier_reg;
    logic [lcgmm_pkg::VALUE_W-1:0]          increment_reg;
    logic [lcgmm_pkg::SCALE_W-1:0]          upper_reg;
    logic [lcgmm_pkg::VALUE_W-1:0]          gen_value;
    int                                     gen_count;
    logic [lcgmm_pkg::VALUE_W-1:0]          min_value;
    logic [lcgmm_pkg::VALUE_W-1:0]          max_value;
    logic [lcgmm_pkg::VALUE_W-1:0]          value_store [lcgmm_pkg::STORE_DEPTH];

    lcg_item_t                              items_to_send [$];
    lcg_result_t                            predicted_results [$];
    lcg_item_t                              in_flight;

    int                                     tx_idle_pct = 28;
    int                                     rx_idle_pct = 66;
    int                                     planned_count;
    int                                     fail_count;
    int                                     words_in;
    int                                     words_out;
    int                                     status_hits [4];

    lcg_with_minmax_normalizer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5ns clk = ~clk;

    function automatic lcg_result_t compute_lcg_result(input lcg_item_t item);
        lcg_result_t                    res;
        logic [63:0]                    acc;
        logic [63:0]                    divisor;
        logic [63:0]                    span;
        logic [63:0]                    offset;
        logic [63:0]                    quot;
        logic [lcgmm_pkg::VALUE_W-1:0]  v;
        res = '{raw: '0, scaled: '0, status: lcgmm_pkg::ST_OK};
        case (item.kind)
            lcgmm_pkg::KIND_GENERATE:
            begin
                if (gen_count >= lcgmm_pkg::STORE_DEPTH)
                begin
                    res.status = lcgmm_pkg::ST_FULL;
                end
                else
                begin
                    // modulus zero acts as 2^31
                    divisor = (modulus_reg == '0) ? (64'd1 << lcgmm_pkg::VALUE_W)
                                                  : 64'(modulus_reg);
                    acc = 64'(multiplier_reg) * 64'(gen_value) + 64'(increment_reg);
                    v = lcgmm_pkg::VALUE_W'(acc % divisor);
                    gen_value = v;
                    value_store[gen_count] = v;
                    gen_count++;
                    if (v < min_value)
                        min_value = v;
                    if (v > max_value)
                        max_value = v;
                    res.raw = v;
                end
            end
            lcgmm_pkg::KIND_READ:
            begin
                if (int'(item.index) >= gen_count)
                begin
                    res.status = lcgmm_pkg::ST_NOT_GENERATED;
                end
                else
                begin
                    v = value_store[item.index];
                    res.raw = v;
                    if (max_value <= min_value)
                    begin
                        res.status = lcgmm_pkg::ST_ZERO_RANGE;
                    end
                    else
                    begin
                        span = 64'(max_value - min_value);
                        offset = (v >= min_value) ? 64'(v - min_value) : 64'd0;
                        quot = (offset * 64'(upper_reg)) / span;
                        res.scaled = (quot > 64'(lcgmm_pkg::SCALE_ONES))
                                   ? lcgmm_pkg::SCALE_ONES
                                   : lcgmm_pkg::SCALE_W'(quot);
                    end
                end
            end
            lcgmm_pkg::KIND_RESTART:
            begin
                gen_value = seed_reg;
                gen_count = 0;
                min_value = lcgmm_pkg::VALUE_ONES;
                max_value = '0;
                res.raw = seed_reg;
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // driver: a word stays on the bus until taken
    always @(posedge clk)
    begin
        lcg_item_t nxt;
        if (s_tvalid && s_tready)
        begin
            predicted_results = {predicted_results, compute_lcg_result(in_flight)};
            words_in++;
        end
        if (!s_tvalid || s_tready)
        begin
            if (rst_n && items_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                nxt = items_to_send.pop_front();
                in_flight = nxt;
                s_tvalid <= 1'b1;
                s_tuser <= nxt.kind;
                s_tdata <= lcgmm_pkg::S_DATA_W'(nxt.index);
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        lcg_result_t got;
        lcg_result_t want;
        if (rst_n)
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        if (m_tvalid && m_tready)
        begin
            got.raw = m_tdata[lcgmm_pkg::VALUE_W-1:0];
            got.scaled = m_tdata[lcgmm_pkg::VALUE_W +: lcgmm_pkg::SCALE_W];
            got.status = lcgmm_pkg::status_t'(m_tuser);
            words_out++;
            status_hits[m_tuser]++;
            if (predicted_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: result word with nothing pending: raw %h scaled %h status %0d",
                             $realtime, got.raw, got.scaled, got.status);
            end
            else
            begin
                want = predicted_results.pop_front();
                if (got.raw !== want.raw || got.scaled !== want.scaled
                    || got.status !== want.status)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: word %0d mismatch: raw %h/%h scaled %h/%h status %0d/%0d",
                                 $realtime, words_out, want.raw, got.raw, want.scaled,
                                 got.scaled, want.status, got.status);
                end
            end
        end
    end

    task automatic set_register(input logic [lcgmm_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [lcgmm_pkg::VALUE_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            lcgmm_pkg::REG_SEED:       seed_reg = val;
            lcgmm_pkg::REG_MODULUS:    modulus_reg = val;
            lcgmm_pkg::REG_MULTIPLIER: multiplier_reg = val;
            lcgmm_pkg::REG_INCREMENT:  increment_reg = val;
            lcgmm_pkg::REG_UPPER:      upper_reg = val[lcgmm_pkg::SCALE_W-1:0];
            default:                   ;
        endcase
    endtask

    task automatic set_generator(input logic [lcgmm_pkg::VALUE_W-1:0] seed,
                                 input logic [lcgmm_pkg::VALUE_W-1:0] modulus,
                                 input logic [lcgmm_pkg::VALUE_W-1:0] mult,
                                 input logic [lcgmm_pkg::VALUE_W-1:0] inc,
                                 input logic [lcgmm_pkg::VALUE_W-1:0] upper);
        set_register(lcgmm_pkg::REG_SEED, seed);
        set_register(lcgmm_pkg::REG_MODULUS, modulus);
        set_register(lcgmm_pkg::REG_MULTIPLIER, mult);
        set_register(lcgmm_pkg::REG_INCREMENT, inc);
        set_register(lcgmm_pkg::REG_UPPER, upper);
    endtask

    task automatic queue_item(input lcgmm_pkg::kind_t kind,
                              input logic [lcgmm_pkg::ADDR_W-1:0] idx);
        lcg_item_t item;
        item.kind = kind;
        item.index = idx;
        items_to_send = {items_to_send, item};
        if (kind == lcgmm_pkg::KIND_RESTART)
            planned_count = 0;
        else if (kind == lcgmm_pkg::KIND_GENERATE && planned_count < lcgmm_pkg::STORE_DEPTH)
            planned_count++;
    endtask

    // mostly restart-generate-read sequences, some stray reads and unused kinds
    task automatic queue_random_items(input int count);
        int roll;
        queue_item(lcgmm_pkg::KIND_RESTART, lcgmm_pkg::ADDR_W'($urandom));
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 4)
                queue_item(lcgmm_pkg::KIND_RESTART, lcgmm_pkg::ADDR_W'($urandom));
            else if (roll < 7)
                queue_item(lcgmm_pkg::KIND_UNUSED, lcgmm_pkg::ADDR_W'($urandom));
            else if (roll < 50)
                queue_item(lcgmm_pkg::KIND_GENERATE, lcgmm_pkg::ADDR_W'($urandom));
            else if (planned_count > 0 && $urandom_range(9) < 8)
                queue_item(lcgmm_pkg::KIND_READ,
                           lcgmm_pkg::ADDR_W'($urandom_range(planned_count - 1)));
            else
                queue_item(lcgmm_pkg::KIND_READ, lcgmm_pkg::ADDR_W'($urandom));
        end
    endtask

    task automatic wait_for_idle();
        while (items_to_send.size() != 0 || s_tvalid || predicted_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        #100ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        seed_reg = lcgmm_pkg::SEED_RESET;
        modulus_reg = lcgmm_pkg::MODULUS_RESET;
        multiplier_reg = lcgmm_pkg::MULTIPLIER_RESET;
        increment_reg = lcgmm_pkg::INCREMENT_RESET;
        upper_reg = lcgmm_pkg::UPPER_RESET;
        gen_value = lcgmm_pkg::SEED_RESET;
        gen_count = 0;
        min_value = lcgmm_pkg::VALUE_ONES;
        max_value = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset configuration: empty store, zero range, restart, unused kind
        queue_item(lcgmm_pkg::KIND_READ, '0);
        queue_item(lcgmm_pkg::KIND_READ, INDEX_TOP);
        queue_item(lcgmm_pkg::KIND_UNUSED, INDEX_TOP);
        queue_item(lcgmm_pkg::KIND_GENERATE, '0);
        queue_item(lcgmm_pkg::KIND_READ, '0);
        repeat (3) queue_item(lcgmm_pkg::KIND_GENERATE, INDEX_TOP);
        queue_item(lcgmm_pkg::KIND_READ, '0);
        queue_item(lcgmm_pkg::KIND_READ, lcgmm_pkg::ADDR_W'(3));
        queue_item(lcgmm_pkg::KIND_READ, lcgmm_pkg::ADDR_W'(4));
        queue_item(lcgmm_pkg::KIND_READ, lcgmm_pkg::ADDR_W'(1));
        queue_item(lcgmm_pkg::KIND_RESTART, '0);
        queue_item(lcgmm_pkg::KIND_READ, '0);
        queue_item(lcgmm_pkg::KIND_GENERATE, '0);
        queue_item(lcgmm_pkg::KIND_UNUSED, '0);
        queue_item(lcgmm_pkg::KIND_GENERATE, '0);
        queue_item(lcgmm_pkg::KIND_READ, '0);
        queue_item(lcgmm_pkg::KIND_READ, lcgmm_pkg::ADDR_W'(1));
        queue_item(lcgmm_pkg::KIND_RESTART, INDEX_TOP);
        queue_item(lcgmm_pkg::KIND_GENERATE, '0);
        queue_item(lcgmm_pkg::KIND_READ, '0);
        wait_for_idle();

        // extremes: seed above modulus, full-scale multiplier, increment and upper bound
        set_generator(lcgmm_pkg::VALUE_ONES, lcgmm_pkg::VALUE_W'(1000), lcgmm_pkg::VALUE_ONES,
                      lcgmm_pkg::VALUE_ONES, lcgmm_pkg::VALUE_W'(lcgmm_pkg::SCALE_ONES));
        for (int k = 0; k < 3; k++)
            set_register(REG_UNMAPPED_LO + lcgmm_pkg::CFG_INDEX_W'(k),
                         lcgmm_pkg::VALUE_W'($urandom));
        queue_random_items(300);
        wait_for_idle();
        queue_random_items(300);
        wait_for_idle();

        tx_idle_pct = 66;
        rx_idle_pct = 28;
        // modulus zero wraps at 2^31, upper bound zero scales to nothing
        set_generator('0, '0, lcgmm_pkg::VALUE_W'($urandom) | lcgmm_pkg::VALUE_W'(1),
                      lcgmm_pkg::VALUE_W'($urandom), '0);
        queue_random_items(450);
        wait_for_idle();
        // constant sequence, every read lands on a zero range
        set_generator(lcgmm_pkg::VALUE_W'($urandom),
                      lcgmm_pkg::VALUE_W'($urandom_range(2147483647, 2)), '0,
                      lcgmm_pkg::VALUE_W'($urandom), lcgmm_pkg::VALUE_W'($urandom));
        queue_random_items(60);
        wait_for_idle();
        set_generator(lcgmm_pkg::VALUE_W'($urandom), lcgmm_pkg::VALUE_W'(1),
                      lcgmm_pkg::VALUE_W'($urandom), lcgmm_pkg::VALUE_W'($urandom),
                      lcgmm_pkg::VALUE_W'($urandom));
        queue_random_items(60);
        wait_for_idle();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_generator(lcgmm_pkg::VALUE_W'($urandom),
                      lcgmm_pkg::VALUE_W'($urandom_range(2147483647, 2)),
                      lcgmm_pkg::VALUE_W'($urandom), lcgmm_pkg::VALUE_W'($urandom),
                      lcgmm_pkg::VALUE_W'($urandom));
        queue_random_items(600);
        wait_for_idle();

        // back-to-back generates with reads spread over the filled part
        set_generator(lcgmm_pkg::VALUE_W'(42), lcgmm_pkg::MODULUS_RESET,
                      lcgmm_pkg::VALUE_W'(48271), '0,
                      lcgmm_pkg::VALUE_W'(lcgmm_pkg::UPPER_RESET));
        queue_item(lcgmm_pkg::KIND_RESTART, '0);
        for (int i = 0; i < 40; i++)
        begin
            queue_item(lcgmm_pkg::KIND_GENERATE, lcgmm_pkg::ADDR_W'($urandom));
            if (i % 8 == 7)
                queue_item(lcgmm_pkg::KIND_READ, lcgmm_pkg::ADDR_W'($urandom_range(i)));
        end
        queue_item(lcgmm_pkg::KIND_READ, INDEX_TOP);
        queue_item(lcgmm_pkg::KIND_READ, '0);
        queue_item(lcgmm_pkg::KIND_UNUSED, lcgmm_pkg::ADDR_W'($urandom));
        for (int i = 0; i < 10; i++)
            queue_item(lcgmm_pkg::KIND_READ, lcgmm_pkg::ADDR_W'($urandom));
        queue_item(lcgmm_pkg::KIND_RESTART, '0);
        queue_item(lcgmm_pkg::KIND_GENERATE, '0);
        queue_item(lcgmm_pkg::KIND_READ, '0);
        wait_for_idle();

        repeat (SETTLE_CYCLES) @(posedge clk);
        fail_count += predicted_results.size();
        $display("covered %0d words in, %0d results out over seven generator settings",
                 words_in, words_out);
        $display("statuses seen: ok %0d, full %0d, not generated %0d, zero range %0d",
                 status_hits[lcgmm_pkg::ST_OK], status_hits[lcgmm_pkg::ST_FULL],
                 status_hits[lcgmm_pkg::ST_NOT_GENERATED],
                 status_hits[lcgmm_pkg::ST_ZERO_RANGE]);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
